// File: rtl/suffix_array_delta_encoder_unit_assert.svh
// Assertion macros used by the checker file of the delta encoder.
// No dependencies.
`ifndef SUFFIX_ARRAY_DELTA_ENCODER_UNIT_ASSERT_SVH
`define SUFFIX_ARRAY_DELTA_ENCODER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SADE_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define SADE_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/sade_pkg.sv
// Package of the delta encoder: operation codes, command kinds, states.
// No dependencies.
`timescale 1ns / 1ps
package sade_pkg;
    localparam int MAX_LEN = 4096;

    localparam logic [2:0] OP_LOAD_OLD = 3'd0;
    localparam logic [2:0] OP_LOAD_SFX = 3'd1;
    localparam logic [2:0] OP_LOAD_NEW = 3'd2;
    localparam logic [2:0] OP_START    = 3'd3;
    localparam logic [2:0] OP_NEXT     = 3'd4;

    localparam logic [1:0] KIND_TOTAL  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_COPY   = 2'd2;

    localparam logic [7:0] THRESHOLD_RESET = 8'd10;
    localparam logic [1:0] REG_THRESHOLD = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE,     // waiting for an item
        ST_SEARCH,   // set up one binary search step
        ST_SFX_RD,   // suffix entry read in flight
        ST_CMP_RD,   // issue byte reads
        ST_CMP_EV,   // evaluate byte pair
        ST_DONE_SRCH,// search finished, decide
        ST_EMIT      // drive the result
    } t_state;
endpackage

// File: rtl/suffix_array_delta_encoder_unit.sv
// Top level of the suffix array delta encoder: stores, search sequencer, APB.
// Depends on sade_pkg.
`timescale 1ns / 1ps
//  channel  | direction | handshake
//  command  | in        | i_start while o_busy low
//  result   | out       | o_result_valid for one cycle, cannot be stalled
//  config   | in/out    | APB, pready always high
//
// Loads and unused operation codes are taken in IDLE and leave busy low. A
// start, and a next that releases a pending copy, go straight to EMIT and keep
// busy high while the result word is shown. Any other next, with the cursor
// short of the new length, runs one binary search per tried new position:
// each step fetches the suffix entry (SEARCH, SFX_RD) and compares byte pairs
// (CMP_RD, CMP_EV); DONE_SRCH decides each position and EMIT shows the result.
// Reset is synchronous and active low; stores are not cleared.
// The result strobe lasts one cycle; the receiver has no way to stall it.
module suffix_array_delta_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_operation,
    input  logic [11:0] i_load_index,
    input  logic [7:0]  i_byte_value,
    input  logic [11:0] i_suffix_start,
    input  logic [12:0] i_old_length,
    input  logic [12:0] i_new_length,
    output logic        o_result_valid,
    output logic [1:0]  o_command_kind,
    output logic [11:0] o_offset,
    output logic [12:0] o_length,
    output logic        o_finished,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sade_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] MAXL = LW'(MAX_LEN);

    // Stores, each with one synchronous read port.
    logic [7:0]    m_old [MAX_LEN];
    logic [AW-1:0] m_sfx [MAX_LEN];
    logic [7:0]    m_new [MAX_LEN];
    logic [7:0]    r_old_q, r_new_q;
    logic [AW-1:0] r_sfx_q;
    logic [AW-1:0] old_ra, new_ra, sfx_ra;

    t_state r_state, n_state;
    logic [7:0]    r_thr;
    logic [LW-1:0] r_cursor, r_old_size, r_new_size;
    logic [LW-1:0] r_pend_len;
    logic [AW-1:0] r_pend_pos;
    logic [LW-1:0] r_lo, r_hi, r_best, r_i, r_lim, r_start, r_x;
    logic [AW-1:0] r_bpos;
    logic          r_scan;    // scanning for the next copy after a short match
    logic [1:0]    r_kind;
    logic [11:0]   r_off;
    logic [12:0]   r_len;
    logic          r_fin;

    // Next-value signals.
    logic [LW-1:0] n_cursor, n_pend_len, n_lo, n_hi, n_best, n_i, n_lim, n_start, n_x;
    logic [AW-1:0] n_pend_pos, n_bpos;
    logic          n_scan, n_fin;
    logic [1:0]    n_kind;
    logic [11:0]   n_off;
    logic [12:0]   n_len;

    logic accept, load_ok;
    logic [LW-1:0] mid, alen, blen, olen_sat, nlen_sat, x_cur;
    logic [LW:0]   lohi;

    assign accept  = i_start && !o_busy;
    assign load_ok = ({1'b0, i_load_index} < 13'(MAX_LEN));
    assign o_busy  = (r_state != ST_IDLE);
    assign pready  = 1'b1;
    assign prdata  = (paddr == REG_THRESHOLD) ? {24'd0, r_thr} : 32'd0;
    assign olen_sat = (i_old_length > 13'(MAX_LEN)) ? MAXL : LW'(i_old_length);
    assign nlen_sat = (i_new_length > 13'(MAX_LEN)) ? MAXL : LW'(i_new_length);
    assign lohi = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid  = lohi[LW:1];
    assign x_cur = r_x;
    assign blen = r_new_size - x_cur;
    assign alen = (LW'(r_sfx_q) < r_old_size) ? r_old_size - LW'(r_sfx_q) : '0;

    assign sfx_ra = mid[AW-1:0];
    always_comb begin
        logic [LW-1:0] ao, an;
        ao = r_start + r_i;
        an = x_cur + r_i;
        old_ra = ao[AW-1:0];
        new_ra = an[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_operation == OP_LOAD_OLD && load_ok)
            m_old[i_load_index[AW-1:0]] <= i_byte_value;
        if (accept && i_operation == OP_LOAD_SFX && load_ok)
            m_sfx[i_load_index[AW-1:0]] <= i_suffix_start[AW-1:0];
        if (accept && i_operation == OP_LOAD_NEW && load_ok)
            m_new[i_load_index[AW-1:0]] <= i_byte_value;
        r_old_q <= m_old[old_ra];
        r_new_q <= m_new[new_ra];
        r_sfx_q <= m_sfx[sfx_ra];
    end

    // Sequencer: one binary search per tried position, byte compare inline.
    always_comb begin
        logic [LW-1:0] lim;
        logic          cmp_lt, done_eq, better;
        n_state = r_state;
        n_cursor = r_cursor; n_pend_len = r_pend_len; n_pend_pos = r_pend_pos;
        n_lo = r_lo; n_hi = r_hi; n_best = r_best; n_i = r_i; n_lim = r_lim;
        n_start = r_start; n_x = r_x; n_bpos = r_bpos; n_scan = r_scan;
        n_kind = r_kind; n_off = r_off; n_len = r_len; n_fin = r_fin;
        lim = (alen < blen) ? alen : blen;
        cmp_lt = 1'b0; done_eq = 1'b0; better = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_operation == OP_START) begin
                    n_cursor = '0; n_pend_len = '0; n_pend_pos = '0;
                    n_kind = KIND_TOTAL; n_off = '0; n_len = 13'(nlen_sat);
                    n_fin = (nlen_sat == '0);
                    n_state = ST_EMIT;
                end else if (accept && i_operation == OP_NEXT) begin
                    if (r_pend_len != '0) begin
                        n_kind = KIND_COPY; n_off = 12'(r_pend_pos);
                        n_len = 13'(r_pend_len);
                        n_fin = ((r_cursor + r_pend_len) >= r_new_size);
                        n_cursor = r_cursor + r_pend_len;
                        n_pend_len = '0; n_pend_pos = '0;
                        n_state = ST_EMIT;
                    end else if (r_cursor < r_new_size) begin
                        n_x = r_cursor; n_scan = 1'b0;
                        n_lo = '0; n_hi = r_old_size; n_best = '0; n_bpos = '0;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (r_lo < r_hi) n_state = ST_SFX_RD;
                else n_state = ST_DONE_SRCH;
            end
            ST_SFX_RD: begin
                n_start = LW'(r_sfx_q); n_lim = lim; n_i = '0;
                n_state = ST_CMP_RD;
            end
            ST_CMP_RD: begin
                if (r_i < r_lim) n_state = ST_CMP_EV;
                else begin
                    // Ran out of bytes: equal when the new side is exhausted.
                    done_eq = (r_lim == blen);
                    better = (r_best < r_i);
                    if (done_eq || better) begin
                        n_best = r_i; n_bpos = r_start[AW-1:0];
                    end
                    if (done_eq) n_state = ST_DONE_SRCH;
                    else begin
                        n_lo = mid + 1'b1; n_state = ST_SEARCH;
                    end
                end
            end
            ST_CMP_EV: begin
                if (r_old_q == r_new_q) begin
                    n_i = r_i + 1'b1; n_state = ST_CMP_RD;
                end else begin
                    cmp_lt = (r_old_q < r_new_q);
                    if (r_best < r_i) begin
                        n_best = r_i; n_bpos = r_start[AW-1:0];
                    end
                    if (cmp_lt) n_lo = mid + 1'b1;
                    else n_hi = mid;
                    n_state = ST_SEARCH;
                end
            end
            ST_DONE_SRCH: begin
                if (!r_scan) begin
                    if (r_best > LW'(r_thr)) begin
                        n_kind = KIND_COPY; n_off = 12'(r_bpos); n_len = 13'(r_best);
                        n_cursor = r_cursor + r_best;
                        n_fin = ((r_cursor + r_best) >= r_new_size);
                        n_state = ST_EMIT;
                    end else begin
                        n_scan = 1'b1; n_x = r_x + 1'b1;
                        n_lo = '0; n_hi = r_old_size; n_best = '0; n_bpos = '0;
                        n_state = (r_x + 1'b1 < r_new_size) ? ST_SEARCH : ST_EMIT;
                        if (r_x + 1'b1 >= r_new_size) begin
                            n_kind = KIND_INSERT; n_off = 12'(r_cursor);
                            n_len = 13'(r_x + 1'b1 - r_cursor);
                            n_cursor = r_x + 1'b1; n_fin = 1'b1;
                        end
                    end
                end else if (r_best > LW'(r_thr)) begin
                    n_pend_len = r_best; n_pend_pos = r_bpos;
                    n_kind = KIND_INSERT; n_off = 12'(r_cursor);
                    n_len = 13'(r_x - r_cursor); n_cursor = r_x; n_fin = 1'b0;
                    n_state = ST_EMIT;
                end else if (r_x + 1'b1 < r_new_size) begin
                    n_x = r_x + 1'b1;
                    n_lo = '0; n_hi = r_old_size; n_best = '0; n_bpos = '0;
                    n_state = ST_SEARCH;
                end else begin
                    n_kind = KIND_INSERT; n_off = 12'(r_cursor);
                    n_len = 13'(r_x + 1'b1 - r_cursor);
                    n_cursor = r_x + 1'b1; n_fin = 1'b1;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_thr <= THRESHOLD_RESET;
            r_cursor <= '0; r_old_size <= '0; r_new_size <= '0;
            r_pend_len <= '0; r_pend_pos <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr == REG_THRESHOLD) r_thr <= pwdata[7:0];
            if (accept && i_operation == OP_START) begin
                r_old_size <= olen_sat; r_new_size <= nlen_sat;
            end
            r_cursor <= n_cursor; r_pend_len <= n_pend_len; r_pend_pos <= n_pend_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo; r_hi <= n_hi; r_best <= n_best; r_i <= n_i; r_lim <= n_lim;
        r_start <= n_start; r_x <= n_x; r_bpos <= n_bpos; r_scan <= n_scan;
        r_kind <= n_kind; r_off <= n_off; r_len <= n_len; r_fin <= n_fin;
    end

    assign o_result_valid = (r_state == ST_EMIT);
    assign o_command_kind = r_kind;
    assign o_offset       = r_off;
    assign o_length       = r_len;
    assign o_finished     = r_fin;
endmodule

// File: rtl/sade_checker.sv
// Port-level checker for the delta encoder, bound to the top level.
// Depends on sade_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "suffix_array_delta_encoder_unit_assert.svh"
module sade_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [2:0]  i_operation,
    input logic        o_result_valid,
    input logic [1:0]  o_command_kind,
    input logic        pready
);
    import sade_pkg::*;
    `SADE_ASSERT_IMPL(a_strobe_busy, i_clk, i_rst_n, o_result_valid, o_busy)
    `SADE_ASSERT_NEXT(a_strobe_one, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    `SADE_ASSERT_NEXT(a_start_total, i_clk, i_rst_n,
        i_start && !o_busy && i_operation == OP_START,
        o_result_valid && o_command_kind == KIND_TOTAL)
    `SADE_ASSERT_IMPL(a_kind_legal, i_clk, i_rst_n, o_result_valid,
        o_command_kind != 2'd3)
    `SADE_ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind suffix_array_delta_encoder_unit sade_checker u_sade_checker (.*);

// File: bench/suffix_array_delta_encoder_unit_test.sv
// Self-checking bench of the suffix array delta encoder: loads buffers and suffix
// arrays, runs encoding phases under several thresholds and checks every command.
// Depends on sade_pkg and suffix_array_delta_encoder_unit.
`timescale 1ns / 1ps
module suffix_array_delta_encoder_unit_test;
    import sade_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] off;
        logic [12:0] len;
        logic        fin;
    } command_t;

    // Tracks the encoder state and the queue of commands still to come.
    class delta_command_tracker;
        byte unsigned old_mem[4096];
        bit [11:0]    sfx_mem[4096];
        byte unsigned new_mem[4096];
        int unsigned  cur, old_sz, new_sz, pend_pos, pend_len, thresh;
        command_t     awaited_q[$];
        int           errors;

        function new();
            thresh = THRESHOLD_RESET;
        endfunction

        // Longest prefix match met along the binary search path.
        function int unsigned longest(int unsigned from, output int unsigned where);
            int unsigned lo, hi, best, bpos, blen, mid, start, alen, lim, i;
            int cmp;
            lo = 0; hi = old_sz; best = 0; bpos = 0;
            blen = new_sz - from;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                start = sfx_mem[mid];
                alen = (start < old_sz) ? old_sz - start : 0;
                lim = (alen < blen) ? alen : blen;
                i = 0;
                while (i < lim && old_mem[start + i] == new_mem[from + i]) i++;
                if (i < lim) cmp = (old_mem[start + i] < new_mem[from + i]) ? -1 : 1;
                else cmp = (lim == blen) ? 0 : -1;
                if (cmp == 0) begin
                    best = i;
                    bpos = start;
                    break;
                end
                if (best < i) begin
                    best = i;
                    bpos = start;
                end
                if (cmp < 0) lo = mid + 1;
                else hi = mid;
            end
            where = bpos;
            return best;
        endfunction

        function void push(logic [1:0] kind, int unsigned off, int unsigned len, bit fin);
            command_t c;
            c.kind = kind;
            c.off = off[11:0];
            c.len = len[12:0];
            c.fin = fin;
            awaited_q.push_back(c);
        endfunction

        function void note_word(logic [2:0] op, logic [11:0] idx, logic [7:0] bval,
                                logic [11:0] sfx, logic [12:0] olen, logic [12:0] nlen);
            int unsigned pos, sim, x, xs, xpos, from;
            case (op)
                OP_LOAD_OLD: old_mem[idx] = bval;
                OP_LOAD_SFX: sfx_mem[idx] = sfx;
                OP_LOAD_NEW: new_mem[idx] = bval;
                OP_START: begin
                    old_sz = (olen > 4096) ? 4096 : olen;
                    new_sz = (nlen > 4096) ? 4096 : nlen;
                    cur = 0;
                    pend_pos = 0;
                    pend_len = 0;
                    push(KIND_TOTAL, 0, new_sz, new_sz == 0);
                end
                OP_NEXT: begin
                    if (pend_len != 0) begin
                        cur += pend_len;
                        push(KIND_COPY, pend_pos, pend_len, cur >= new_sz);
                        pend_pos = 0;
                        pend_len = 0;
                    end else if (cur < new_sz) begin
                        sim = longest(cur, pos);
                        if (sim > thresh) begin
                            cur += sim;
                            push(KIND_COPY, pos, sim, cur >= new_sz);
                        end else begin
                            from = cur;
                            xs = 0;
                            xpos = 0;
                            for (x = cur + 1; x < new_sz; x++) begin
                                xs = longest(x, xpos);
                                if (xs > thresh) break;
                            end
                            cur = x;
                            if (x < new_sz && xs > thresh) begin
                                pend_pos = xpos;
                                pend_len = xs;
                            end
                            push(KIND_INSERT, from, x - from, cur >= new_sz && pend_len == 0);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(command_t got);
            command_t want;
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected command kind %0d offset %0d length %0d",
                         $time, got.kind, got.off, got.len);
                errors++;
                return;
            end
            want = awaited_q.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.off !== want.off) begin
                $display("%0t: offset expected %0d actual %0d", $time, want.off, got.off);
                errors++;
            end
            if (got.len !== want.len) begin
                $display("%0t: length expected %0d actual %0d", $time, want.len, got.len);
                errors++;
            end
            if (got.fin !== want.fin) begin
                $display("%0t: finished expected %0d actual %0d", $time, want.fin, got.fin);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_operation = '0;
    logic [11:0] i_load_index = '0;
    logic [7:0]  i_byte_value = '0;
    logic [11:0] i_suffix_start = '0;
    logic [12:0] i_old_length = '0;
    logic [12:0] i_new_length = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_busy, o_result_valid, o_finished, pready;
    logic [1:0]  o_command_kind;
    logic [11:0] o_offset;
    logic [12:0] o_length;
    logic [31:0] prdata;

    suffix_array_delta_encoder_unit dut (.*);

    delta_command_tracker tracker = new();

    // Local copy of the old buffer, used to build the new buffer and sort the suffix array.
    byte unsigned old_image[4096];
    int           order[4096];
    int           words_sent;
    int           burst_left;
    bit           steady;

    always #6 i_clk = ~i_clk;

    // The result strobe lasts one cycle and cannot be stalled, so every
    // rising edge with the strobe high carries one command.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            tracker.check_word({o_command_kind, o_offset, o_length, o_finished});
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // Presents one word and holds it until the block takes it. The strobe
    // stays high into the next word of a burst; a gap lowers it first.
    // Fields arrive as plain integers and are cut to the port widths here.
    task automatic drive_word(int unsigned op, int unsigned idx, int unsigned bval,
                              int unsigned sfx, int unsigned olen, int unsigned nlen);
        int gap;
        i_start        <= 1'b1;
        i_operation    <= op[2:0];
        i_load_index   <= idx[11:0];
        i_byte_value   <= bval[7:0];
        i_suffix_start <= sfx[11:0];
        i_old_length   <= olen[12:0];
        i_new_length   <= nlen[12:0];
        do @(posedge i_clk); while (o_busy);
        tracker.note_word(op[2:0], idx[11:0], bval[7:0], sfx[11:0], olen[12:0],
                          nlen[12:0]);
        words_sent++;
        if (burst_left > 0 || steady) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Waits until every awaited command has arrived and the block is idle.
    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_THRESHOLD;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tracker.thresh = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[7:0] !== value) begin
            $display("%0t: threshold readback expected %0d actual %0d",
                     $time, value, prdata[7:0]);
            tracker.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic bit suffix_less(int a, int b, int n);
        while (a < n && b < n) begin
            if (old_image[a] != old_image[b]) return old_image[a] < old_image[b];
            a++;
            b++;
        end
        return a >= n && b < n;
    endfunction

    // One encoding session: threshold, buffers, suffix array, start and the
    // commands up to the end of the new buffer, plus a few past the end.
    task automatic run_phase(int ol, int nl, int thr, bit scramble, bit restart_mid);
        int base, j, k, run, src, key, nexts;
        logic [7:0] b;
        settle();
        write_threshold(8'(thr));
        base = $urandom_range(0, 252);
        for (j = 0; j < ol; j++) begin
            old_image[j] = 8'(base + $urandom_range(0, 3));
            drive_word(OP_LOAD_OLD, j, old_image[j], $urandom, $urandom, $urandom);
        end
        // The new buffer is mostly pieces of the old one, so copies occur.
        j = 0;
        while (j < nl) begin
            if (ol > 0 && $urandom_range(0, 2) != 0) begin
                src = $urandom_range(0, ol - 1);
                run = $urandom_range(1, 20);
                for (k = 0; k < run && j < nl && src + k < ol; k++) begin
                    b = old_image[src + k];
                    if ($urandom_range(0, 15) == 0) b = 8'(base + $urandom_range(0, 3));
                    drive_word(OP_LOAD_NEW, j, b, $urandom, $urandom, $urandom);
                    j++;
                end
            end else begin
                drive_word(OP_LOAD_NEW, j, base + $urandom_range(0, 3),
                           $urandom, $urandom, $urandom);
                j++;
            end
            if ($urandom_range(0, 19) == 0)
                drive_word($urandom_range(5, 7), $urandom, $urandom, $urandom,
                           $urandom, $urandom);
        end
        for (j = 0; j < ol; j++) begin
            key = j;
            for (k = j; k > 0 && suffix_less(key, order[k - 1], ol); k--)
                order[k] = order[k - 1];
            order[k] = key;
        end
        // A scrambled array is legal input; an entry at or past the old length
        // stands for an empty suffix.
        if (scramble && ol > 1) begin
            order[$urandom_range(0, ol - 1)] = $urandom_range(ol, 4095);
            k = $urandom_range(0, ol - 1);
            key = order[k];
            order[k] = order[0];
            order[0] = key;
        end
        for (j = 0; j < ol; j++)
            drive_word(OP_LOAD_SFX, j, $urandom, order[j], $urandom, $urandom);
        if ($urandom_range(0, 3) == 0)
            drive_word(OP_START, $urandom, $urandom, $urandom,
                       $urandom_range(4097, 8191), $urandom_range(0, 8191));
        drive_word(OP_START, $urandom, $urandom, $urandom, ol, nl);
        nexts = 0;
        while (!(tracker.cur >= tracker.new_sz && tracker.pend_len == 0)
               && nexts < nl + 8) begin
            drive_word(OP_NEXT, $urandom, $urandom, $urandom, $urandom, $urandom);
            nexts++;
            if (restart_mid && nexts == 2)
                drive_word(OP_START, $urandom, $urandom, $urandom, ol, nl);
            if (nl > 0 && $urandom_range(0, 9) == 0)
                drive_word(OP_LOAD_NEW, $urandom_range(0, nl - 1), base + $urandom_range(0, 3),
                           $urandom, $urandom, $urandom);
        end
        repeat (2) drive_word(OP_NEXT, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        int thr;
        words_sent = 0;
        burst_left = 0;
        steady = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: next before start, unused codes, saturated lengths,
        // extreme indexes and values, empty buffers.
        steady = 1'b1;
        drive_word(OP_NEXT, '0, '0, '0, '0, '0);
        drive_word(3'd5, '1, '1, '1, '1, '1);
        drive_word(3'd6, '0, '0, '0, '0, '0);
        drive_word(3'd7, '1, '1, '1, '1, '1);
        drive_word(OP_LOAD_OLD, 12'd4095, 8'd255, '0, '0, '0);
        drive_word(OP_LOAD_SFX, 12'd4095, '0, 12'd4095, '0, '0);
        drive_word(OP_LOAD_NEW, 12'd4095, 8'd255, '0, '0, '0);
        drive_word(OP_START, '0, '0, '0, 13'd8191, 13'd8191);
        drive_word(OP_START, '0, '0, '0, 13'd4096, 13'd4096);
        drive_word(OP_START, '0, '0, '0, 13'd0, 13'd0);
        drive_word(OP_NEXT, '0, '0, '0, '0, '0);
        steady = 1'b0;
        run_phase(0, 5, THRESHOLD_RESET, 1'b0, 1'b0);
        run_phase(8, 8, 0, 1'b0, 1'b0);
        run_phase(12, 14, 255, 1'b0, 1'b0);
        run_phase(16, 20, 2, 1'b1, 1'b1);

        // Random part: one larger session first, then mostly small ones.
        while (words_sent < 580) begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0: thr = 0;
                1: thr = 255;
                2: thr = THRESHOLD_RESET;
                3: thr = $urandom_range(0, 4);
                default: thr = $urandom_range(0, 12);
            endcase
            if (words_sent < 250)
                run_phase(100, 100, thr, 1'b0, 1'b0);
            else
                run_phase($urandom_range(0, 40), $urandom_range(0, 40), thr,
                          $urandom_range(0, 4) == 0, $urandom_range(0, 5) == 0);
        end

        settle();
        repeat (100) @(posedge i_clk);
        if (tracker.awaited_q.size() != 0)
            $display("%0t: %0d commands never arrived", $time, tracker.awaited_q.size());
        if (tracker.errors == 0 && tracker.awaited_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
